// ----- design/mwf_pkg.sv -----
`timescale 1ns / 1ps

package mwf_pkg;

	// default sample width, sign taken from this bit count
	localparam int SAMPLE_BITS_DEF = 16;

	// depth of each decoupling queue
	localparam int QUEUE_DEPTH = 2;

	// sensor side codes
	localparam logic [1:0] SIDE_MISSING = 2'd0;
	localparam logic [1:0] SIDE_IN      = 2'd1;
	localparam logic [1:0] SIDE_OUT     = 2'd2;

	// register indexes of the config port
	typedef enum logic [2:0] {
		REG_TARGET_SPEED   = 3'd0,
		REG_LINE_DIRECTION = 3'd1,
		REG_FACING_MARGIN  = 3'd2,
		REG_NEAR_THRESHOLD = 3'd3,
		REG_FAR_THRESHOLD  = 3'd4
	} reg_idx_t;

	// config reset values
	localparam logic [14:0] TARGET_SPEED_RST   = 15'd0;
	localparam logic        LINE_DIRECTION_RST = 1'b0;
	localparam logic [7:0]  FACING_MARGIN_RST  = 8'd26;
	localparam logic [14:0] NEAR_THRESHOLD_RST = 15'd15000;
	localparam logic [14:0] FAR_THRESHOLD_RST  = 15'd26000;

	// controller modes
	typedef enum logic [2:0] {
		MODE_IDLE    = 3'd0,
		MODE_START   = 3'd1,
		MODE_FINDDIR = 3'd2,
		MODE_GOTO    = 3'd3,
		MODE_ALIGN   = 3'd4,
		MODE_TRACE   = 3'd5
	} mode_t;

	// orientation classes from the front end
	typedef enum logic [3:0] {
		ORI_MISSING    = 4'd0,
		ORI_IN_NORMAL  = 4'd1,
		ORI_IN_LHRL    = 4'd2,
		ORI_IN_LLRH    = 4'd3,
		ORI_OUT_NORMAL = 4'd4,
		ORI_OUT_LHRL   = 4'd5,
		ORI_OUT_LLRH   = 4'd6,
		ORI_ALIGNED    = 4'd7,
		ORI_REVERSE    = 4'd8
	} orient_t;

	typedef struct packed {
		logic [14:0] target_speed;
		logic        line_direction;
		logic [7:0]  facing_margin;
		logic [14:0] near_threshold;
		logic [14:0] far_threshold;
	} cfg_t;

	typedef struct packed {
		logic               kind;
		logic [1:0]         left_side;
		logic [1:0]         right_side;
		logic signed [15:0] left_level;
		logic signed [15:0] right_level;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] turn_rate;
		logic [14:0]        forward_speed;
		logic               wire_lost;
		mode_t              mode_now;
	} out_item_t;

	// classified sample handed from front to back
	typedef struct packed {
		logic       kind;
		logic [1:0] left_side;
		logic [1:0] right_side;
		orient_t    ori;
		logic       l_gt_r;
		logic       l_lt_r;
		logic       l_near;
		logic       r_near;
		logic       both_far;
	} class_t;

endpackage

// ----- design/mwf_queue.sv -----
`timescale 1ns / 1ps

module mwf_queue #(
	parameter type item_t = logic
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t wdata,
	output logic  full,
	input  logic  pop,
	output item_t rdata,
	output logic  empty
);
	import mwf_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	item_t            store_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = store_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[wr_ptr_q] <= wdata;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- design/mwf_front.sv -----
`timescale 1ns / 1ps

module mwf_front #(
	parameter int SAMPLE_BITS = mwf_pkg::SAMPLE_BITS_DEF
) (
	input  mwf_pkg::in_item_t item,
	input  mwf_pkg::cfg_t     cfg,
	output mwf_pkg::class_t   cls
);
	import mwf_pkg::*;

	localparam int SB = SAMPLE_BITS;
	localparam int CW = ((SB > 16) ? SB : 16) + 1;
	localparam int PW = SB + 9;

	logic [SB-1:0]        raw_l;
	logic [SB-1:0]        raw_r;
	logic signed [CW-1:0] lvl_l;
	logic signed [CW-1:0] lvl_r;
	logic signed [CW-1:0] near_s;
	logic signed [CW-1:0] far_s;
	logic [SB-1:0]        abs_l;
	logic [SB-1:0]        abs_r;
	logic [8:0]           bal_k;
	logic [PW-1:0]        prod_lk;
	logic [PW-1:0]        prod_rk;
	logic [PW-1:0]        scaled_l;
	logic [PW-1:0]        scaled_r;
	logic                 normal;
	logic                 missing;
	orient_t              ori;

	// take the sample bits, sign from the top sample bit
	if (SB > 16) begin : g_wide
		assign raw_l = {{(SB - 16){1'b0}}, item.left_level};
		assign raw_r = {{(SB - 16){1'b0}}, item.right_level};
	end else begin : g_narrow
		assign raw_l = item.left_level[SB-1:0];
		assign raw_r = item.right_level[SB-1:0];
	end

	assign lvl_l  = $signed({{(CW - SB){raw_l[SB-1]}}, raw_l});
	assign lvl_r  = $signed({{(CW - SB){raw_r[SB-1]}}, raw_r});
	assign near_s = $signed({{(CW - 15){1'b0}}, cfg.near_threshold});
	assign far_s  = $signed({{(CW - 15){1'b0}}, cfg.far_threshold});

	// absolute levels and balance margin test
	assign abs_l    = raw_l[SB-1] ? (~raw_l + 1'b1) : raw_l;
	assign abs_r    = raw_r[SB-1] ? (~raw_r + 1'b1) : raw_r;
	assign bal_k    = {1'b1, cfg.facing_margin};
	assign prod_lk  = PW'(abs_l) * PW'(bal_k);
	assign prod_rk  = PW'(abs_r) * PW'(bal_k);
	assign scaled_l = {1'b0, abs_l, 8'h00};
	assign scaled_r = {1'b0, abs_r, 8'h00};
	assign normal   = (scaled_l < prod_rk) && (scaled_r < prod_lk);

	assign missing = (item.left_side == SIDE_MISSING) || (item.right_side == SIDE_MISSING)
		|| (item.left_side > SIDE_OUT) || (item.right_side > SIDE_OUT);

	// orientation class
	always_comb begin
		if (missing) begin
			ori = ORI_MISSING;
		end else if (item.left_side == item.right_side) begin
			if (item.left_side == SIDE_IN) begin
				if (normal) begin
					ori = ORI_IN_NORMAL;
				end else if (abs_l > abs_r) begin
					ori = ORI_IN_LHRL;
				end else begin
					ori = ORI_IN_LLRH;
				end
			end else begin
				if (normal) begin
					ori = ORI_OUT_NORMAL;
				end else if (abs_l > abs_r) begin
					ori = ORI_OUT_LHRL;
				end else begin
					ori = ORI_OUT_LLRH;
				end
			end
		end else if ((item.left_side == SIDE_IN) == (cfg.line_direction == 1'b0)) begin
			ori = ORI_ALIGNED;
		end else begin
			ori = ORI_REVERSE;
		end
	end

	// pass-through fields, orientation and the level comparisons the back end needs
	always_comb begin
		cls.kind       = item.kind;
		cls.left_side  = item.left_side;
		cls.right_side = item.right_side;
		cls.ori        = ori;
		cls.l_gt_r     = lvl_l > lvl_r;
		cls.l_lt_r     = lvl_l < lvl_r;
		cls.l_near     = lvl_l < near_s;
		cls.r_near     = lvl_r < near_s;
		cls.both_far   = (lvl_l > far_s) && (lvl_r > far_s);
	end

endmodule

// ----- design/mwf_back.sv -----
`timescale 1ns / 1ps

module mwf_back (
	input  logic               clk,
	input  logic               arst_n,
	input  mwf_pkg::cfg_t      cfg,
	input  mwf_pkg::class_t    cls,
	input  logic               cls_empty,
	output logic               cls_pop,
	output mwf_pkg::out_item_t result,
	input  logic               result_full,
	output logic               result_push
);
	import mwf_pkg::*;

	localparam logic [15:0] TenthRecip = 16'd52429;
	localparam int          TenthShift = 19;

	mode_t              mode_q;
	mode_t              mode_d;
	logic [1:0]         entry_q;
	logic [1:0]         entry_d;
	logic               step;
	logic [14:0]        t_full;
	logic [14:0]        t_quarter;
	logic [16:0]        t_triple;
	logic [14:0]        t_3quarter;
	logic [30:0]        tenth_prod;
	logic [14:0]        t_tenth;
	logic signed [15:0] turn;
	logic [14:0]        speed;
	logic               lost;
	logic               same_side;
	logic               ccw;
	logic               trace_neg;

	assign step        = !cls_empty && !result_full;
	assign cls_pop     = step;
	assign result_push = step;

	// fixed fractions of the target speed
	assign t_full     = cfg.target_speed;
	assign t_quarter  = {2'b00, t_full[14:2]};
	assign t_triple   = {2'b00, t_full} + {1'b0, t_full, 1'b0};
	assign t_3quarter = t_triple[16:2];
	assign tenth_prod = 31'(t_full) * 31'(TenthRecip);
	assign t_tenth    = 15'(tenth_prod >> TenthShift);

	assign same_side = (entry_q == cls.left_side) && (entry_q == cls.right_side);
	assign ccw       = (cfg.line_direction == 1'b0) ? (cls.left_side == SIDE_OUT)
	                                               : (cls.left_side == SIDE_IN);
	assign trace_neg = (cls.left_side == SIDE_IN) == (cfg.line_direction == 1'b0);

	// next mode and entry side
	always_comb begin
		mode_d  = mode_q;
		entry_d = entry_q;
		if (cls.kind) begin
			mode_d = MODE_START;
		end else if (cls.ori != ORI_MISSING) begin
			case (mode_q)
				MODE_START: begin
					if (cls.ori inside {ORI_IN_NORMAL, ORI_IN_LHRL, ORI_IN_LLRH,
					                    ORI_OUT_NORMAL}) begin
						entry_d = cls.left_side;
						mode_d  = MODE_GOTO;
					end else if (cls.ori inside {ORI_OUT_LHRL, ORI_OUT_LLRH}) begin
						mode_d = MODE_FINDDIR;
					end else if (cls.ori == ORI_ALIGNED) begin
						mode_d = MODE_TRACE;
					end else begin
						mode_d  = MODE_ALIGN;
						entry_d = SIDE_IN;
					end
				end
				MODE_FINDDIR: begin
					if (!(cls.ori inside {ORI_OUT_LHRL, ORI_OUT_LLRH})) begin
						mode_d = MODE_START;
					end
				end
				MODE_GOTO: begin
					if (!same_side) begin
						mode_d = (cls.ori == ORI_ALIGNED) ? MODE_TRACE : MODE_ALIGN;
					end
				end
				MODE_ALIGN: begin
					if (cls.ori == ORI_ALIGNED) begin
						mode_d = MODE_TRACE;
					end
				end
				default: ;
			endcase
		end
	end

	// turn and speed commands
	always_comb begin
		turn  = '0;
		speed = '0;
		lost  = 1'b0;
		if (!cls.kind) begin
			if (cls.ori == ORI_MISSING) begin
				lost = 1'b1;
			end else begin
				case (mode_q)
					MODE_FINDDIR: begin
						if (cls.ori == ORI_OUT_LHRL) begin
							turn = $signed({1'b0, t_full});
						end else if (cls.ori == ORI_OUT_LLRH) begin
							turn = -$signed({1'b0, t_full});
						end
					end
					MODE_GOTO: begin
						if (same_side) begin
							if (cls.l_gt_r) begin
								turn = $signed({1'b0, t_quarter});
							end else if (cls.l_lt_r) begin
								turn = -$signed({1'b0, t_quarter});
							end
							speed = t_full;
						end
					end
					MODE_ALIGN: begin
						if (cls.ori != ORI_ALIGNED) begin
							turn  = ccw ? $signed({1'b0, t_full}) : -$signed({1'b0, t_full});
							speed = t_quarter;
						end
					end
					MODE_TRACE: begin
						speed = t_full;
						if (cls.left_side == cls.right_side) begin
							turn = trace_neg ? -$signed({1'b0, t_3quarter})
							                 : $signed({1'b0, t_3quarter});
						end else if (cls.l_near) begin
							turn = $signed({1'b0, t_quarter});
						end else if (cls.r_near) begin
							turn = -$signed({1'b0, t_quarter});
						end else if (cls.both_far) begin
							turn = -$signed({1'b0, t_tenth});
						end
					end
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		result.turn_rate     = turn;
		result.forward_speed = speed;
		result.wire_lost     = lost;
		result.mode_now      = mode_d;
	end

	// mode state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			entry_q <= SIDE_MISSING;
		end else if (step) begin
			mode_q  <= mode_d;
			entry_q <= entry_d;
		end
	end

endmodule

// ----- design/magnetic_wire_follow_controller.sv -----
`timescale 1ns / 1ps
// channel   direction  handshake           payload
// item      in         push / full         mwf_pkg::in_item_t
// result    out        empty / pop         mwf_pkg::out_item_t
// config    in         cfg_we (no wait)    cfg_index, cfg_data
//
// One item per cycle while the result queue is drained; an item is classified into the
// classify queue at the accepting edge, then the back end steps it into the result queue,
// where it can be popped; the back end waits while the result queue is full.
// Reset sets the mode to idle, clears the entry side and both queues and loads the config reset values.
// full rises only when the classify queue holds two items and the back end is held
// by a full result queue; the front keeps taking items while a result waits.

module magnetic_wire_follow_controller #(
	parameter int SAMPLE_BITS = mwf_pkg::SAMPLE_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  mwf_pkg::in_item_t  item,
	output logic               empty,
	input  logic               pop,
	output mwf_pkg::out_item_t result,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [14:0]        cfg_data
);
	import mwf_pkg::*;

	cfg_t      cfg_q;
	class_t    cls_front;
	class_t    cls_back;
	logic      cls_empty;
	logic      cls_pop;
	out_item_t res_back;
	logic      res_full;
	logic      res_push;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_speed   <= TARGET_SPEED_RST;
			cfg_q.line_direction <= LINE_DIRECTION_RST;
			cfg_q.facing_margin  <= FACING_MARGIN_RST;
			cfg_q.near_threshold <= NEAR_THRESHOLD_RST;
			cfg_q.far_threshold  <= FAR_THRESHOLD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TARGET_SPEED:   cfg_q.target_speed   <= cfg_data;
				REG_LINE_DIRECTION: cfg_q.line_direction <= cfg_data[0];
				REG_FACING_MARGIN:  cfg_q.facing_margin  <= cfg_data[7:0];
				REG_NEAR_THRESHOLD: cfg_q.near_threshold <= cfg_data;
				REG_FAR_THRESHOLD:  cfg_q.far_threshold  <= cfg_data;
				default: ;
			endcase
		end
	end

	// classify incoming beats
	mwf_front #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_front (
		.item(item),
		.cfg (cfg_q),
		.cls (cls_front)
	);

	mwf_queue #(
		.item_t(class_t)
	) u_cls_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (cls_front),
		.full  (full),
		.pop   (cls_pop),
		.rdata (cls_back),
		.empty (cls_empty)
	);

	// mode machine and command generation
	mwf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.cls        (cls_back),
		.cls_empty  (cls_empty),
		.cls_pop    (cls_pop),
		.result     (res_back),
		.result_full(res_full),
		.result_push(res_push)
	);

	mwf_queue #(
		.item_t(out_item_t)
	) u_res_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (res_back),
		.full  (res_full),
		.pop   (pop),
		.rdata (result),
		.empty (empty)
	);

endmodule

// ----- design/mwf_checker.sv -----
`timescale 1ns / 1ps

module mwf_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               empty,
	input logic               pop,
	input mwf_pkg::out_item_t result
);
	import mwf_pkg::*;

	// a waiting result beat holds until taken
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("result beat changed while waiting");

	// lost wire gives zero commands
	a_lost_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.wire_lost) |-> (result.turn_rate == '0 && result.forward_speed == '0))
		else $error("commands not zero on lost wire");

	// forward motion only in find direction, go to line, aligning or trace
	a_speed_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.forward_speed != '0) |->
		(result.mode_now == MODE_GOTO || result.mode_now == MODE_ALIGN
		 || result.mode_now == MODE_TRACE || result.mode_now == MODE_FINDDIR))
		else $error("forward speed in a mode without motion");

	// idle and start give no commands
	a_rest_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (result.mode_now == MODE_IDLE || result.mode_now == MODE_START)) |->
		(result.turn_rate == '0 && result.forward_speed == '0))
		else $error("commands in idle or start");

endmodule

bind magnetic_wire_follow_controller mwf_checker u_mwf_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.empty (empty),
	.pop   (pop),
	.result(result)
);

// ----- verif/magnetic_wire_follow_controller_tb.sv -----
`timescale 1ns / 1ps

module magnetic_wire_follow_controller_tb;
	import mwf_pkg::*;

	localparam int CYCLE_LIMIT = 300000;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      push;
	logic      full;
	in_item_t  item;
	logic      empty;
	logic      pop;
	out_item_t result;
	logic      cfg_we;
	logic [2:0]  cfg_index;
	logic [14:0] cfg_data;

	// shadow registers and controller state of the predictor
	int         tgt_speed;
	logic       follow_rev;
	int         margin;
	int         near_lvl;
	int         far_lvl;
	mode_t      nav_mode;
	logic [1:0] entry_sd;

	out_item_t pending_cmds[$];
	out_item_t want;
	int errors;
	int items_sent;
	int cmds_checked;
	int lost_seen;
	int mode_hits[8];
	int cycles;
	int gap_pct;
	int stall_pct;
	int pop_hold;
	logic calm;

	magnetic_wire_follow_controller dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.item(item),
		.empty(empty),
		.pop(pop),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// orientation of one sensor sample
	function automatic orient_t classify_sample(in_item_t it);
		logic [1:0] sl;
		logic [1:0] sr;
		longint a;
		longint b;
		longint k;
		orient_t base;
		sl = it.left_side;
		sr = it.right_side;
		if (sl == SIDE_MISSING || sr == SIDE_MISSING || sl > SIDE_OUT || sr > SIDE_OUT)
			return ORI_MISSING;
		if (sl == sr) begin
			a = longint'($signed(it.left_level));
			b = longint'($signed(it.right_level));
			if (a < 0)
				a = -a;
			if (b < 0)
				b = -b;
			k = 256 + margin;
			base = (sl == SIDE_IN) ? ORI_IN_NORMAL : ORI_OUT_NORMAL;
			if (256 * a < b * k && 256 * b < a * k)
				return base;
			return (a > b) ? orient_t'(base + 4'd1) : orient_t'(base + 4'd2);
		end
		return ((sl == SIDE_IN) == (follow_rev == 1'b0)) ? ORI_ALIGNED : ORI_REVERSE;
	endfunction

	// advance the follow controller by one beat and give its commands
	function automatic out_item_t follow_step(in_item_t it);
		out_item_t r;
		orient_t o;
		longint vl;
		longint vr;
		int t;
		int turn;
		int speed;
		logic lost;
		logic ccw;
		logic neg;
		t = tgt_speed;
		turn = 0;
		speed = 0;
		lost = 1'b0;
		vl = longint'($signed(it.left_level));
		vr = longint'($signed(it.right_level));
		if (it.kind) begin
			nav_mode = MODE_START;
		end else begin
			o = classify_sample(it);
			if (o == ORI_MISSING) begin
				lost = 1'b1;
			end else begin
				case (nav_mode)
					MODE_START: begin
						if (o == ORI_IN_NORMAL || o == ORI_IN_LHRL || o == ORI_IN_LLRH ||
								o == ORI_OUT_NORMAL) begin
							entry_sd = it.left_side;
							nav_mode = MODE_GOTO;
						end else if (o == ORI_OUT_LHRL || o == ORI_OUT_LLRH) begin
							nav_mode = MODE_FINDDIR;
						end else if (o == ORI_ALIGNED) begin
							nav_mode = MODE_TRACE;
						end else begin
							nav_mode = MODE_ALIGN;
							entry_sd = SIDE_IN;
						end
					end
					MODE_FINDDIR: begin
						if (o == ORI_OUT_LHRL)
							turn = t;
						else if (o == ORI_OUT_LLRH)
							turn = -t;
						else
							nav_mode = MODE_START;
					end
					MODE_GOTO: begin
						if (entry_sd != it.left_side || entry_sd != it.right_side) begin
							nav_mode = (o == ORI_ALIGNED) ? MODE_TRACE : MODE_ALIGN;
						end else begin
							if (vl > vr)
								turn = t / 4;
							else if (vl < vr)
								turn = -(t / 4);
							speed = t;
						end
					end
					MODE_ALIGN: begin
						if (o == ORI_ALIGNED) begin
							nav_mode = MODE_TRACE;
						end else begin
							ccw = follow_rev ? (it.left_side == SIDE_IN) :
								(it.left_side == SIDE_OUT);
							turn = ccw ? t : -t;
							speed = t / 4;
						end
					end
					MODE_TRACE: begin
						speed = t;
						if (it.left_side == it.right_side) begin
							neg = (it.left_side == SIDE_IN) == (follow_rev == 1'b0);
							turn = neg ? -((3 * t) / 4) : (3 * t) / 4;
						end else if (vl < near_lvl) begin
							turn = t / 4;
						end else if (vr < near_lvl) begin
							turn = -(t / 4);
						end else if (vl > far_lvl && vr > far_lvl) begin
							turn = -(t / 10);
						end
					end
					default: ;
				endcase
			end
		end
		r.turn_rate = 16'(turn);
		r.forward_speed = 15'(speed);
		r.wire_lost = lost;
		r.mode_now = nav_mode;
		return r;
	endfunction

	// magnitude clamped to the positive range, sign at random
	function automatic logic signed [15:0] signed_level(int mag);
		if (mag < 0)
			mag = 0;
		if (mag > 32767)
			mag = 32767;
		return $urandom_range(0, 1) ? 16'(-mag) : 16'(mag);
	endfunction

	function automatic in_item_t sample(logic [1:0] ls, logic [1:0] rs, int lv, int rv);
		in_item_t it;
		it.kind = 1'b0;
		it.left_side = ls;
		it.right_side = rs;
		it.left_level = 16'(lv);
		it.right_level = 16'(rv);
		return it;
	endfunction

	// random beat, weighted towards valid sensor samples near the decision edges
	function automatic in_item_t make_sample();
		in_item_t it;
		int pick;
		int a;
		int b;
		int extremes[5];
		extremes = '{-32768, 32767, 0, -1, 1};
		it = in_item_t'($bits(in_item_t)'({$urandom, $urandom}));
		pick = $urandom_range(0, 99);
		if (pick < 6) begin
			it.kind = 1'b1;
			return it;
		end
		it.kind = 1'b0;
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			if ($urandom_range(0, 1))
				it.left_side = $urandom_range(0, 1) ? 2'd3 : SIDE_MISSING;
			else
				it.right_side = $urandom_range(0, 1) ? 2'd3 : SIDE_MISSING;
		end else if (pick < 55) begin
			it.left_side = $urandom_range(0, 1) ? SIDE_IN : SIDE_OUT;
			it.right_side = it.left_side;
		end else begin
			it.left_side = $urandom_range(0, 1) ? SIDE_IN : SIDE_OUT;
			it.right_side = (it.left_side == SIDE_IN) ? SIDE_OUT : SIDE_IN;
		end
		case ($urandom_range(0, 4))
			0: ;
			1: begin
				// around the balance margin
				a = $urandom_range(0, 32767);
				b = (a * (256 + margin)) / 256 + $urandom_range(0, 4) - 2;
				if ($urandom_range(0, 1)) begin
					it.left_level = signed_level(a);
					it.right_level = signed_level(b);
				end else begin
					it.left_level = signed_level(b);
					it.right_level = signed_level(a);
				end
			end
			2: begin
				// around the trace thresholds, mostly positive
				a = ($urandom_range(0, 1) ? near_lvl : far_lvl) + $urandom_range(0, 6) - 3;
				b = ($urandom_range(0, 1) ? near_lvl : far_lvl) + $urandom_range(0, 6) - 3;
				it.left_level = ($urandom_range(0, 3) == 0) ? signed_level(a) :
					16'(a < 0 ? 0 : (a > 32767 ? 32767 : a));
				it.right_level = ($urandom_range(0, 3) == 0) ? signed_level(b) :
					16'(b < 0 ? 0 : (b > 32767 ? 32767 : b));
			end
			3: begin
				it.left_level = 16'(extremes[$urandom_range(0, 4)]);
				it.right_level = 16'(extremes[$urandom_range(0, 4)]);
			end
			default: it.right_level = it.left_level;
		endcase
		return it;
	endfunction

	// issue one beat and hold it until taken
	task automatic send_item(in_item_t it);
		if (!calm && gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		push <= 1'b1;
		item <= it;
		do
			@(posedge clk);
		while (full !== 1'b0);
		items_sent++;
	endtask

	// stop sending and wait for every outstanding command
	task automatic drain();
		push <= 1'b0;
		@(posedge clk);
		while (pending_cmds.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [14:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic set_config(int ts, int dir, int mg, int nr, int fr);
		write_reg(REG_TARGET_SPEED, 15'(ts));
		write_reg(REG_LINE_DIRECTION, 15'(dir));
		write_reg(REG_FACING_MARGIN, 15'(mg));
		write_reg(REG_NEAR_THRESHOLD, 15'(nr));
		write_reg(REG_FAR_THRESHOLD, 15'(fr));
		cfg_we <= 1'b0;
		tgt_speed = ts;
		follow_rev = dir[0];
		margin = mg;
		near_lvl = nr;
		far_lvl = fr;
	endtask

	task automatic run_random(int n);
		int gaps[3];
		gaps = '{0, 10, 30};
		for (int i = 0; i < n; i++) begin
			if (i % 50 == 0)
				gap_pct = gaps[$urandom_range(0, 2)];
			send_item(make_sample());
		end
	endtask

	// idle behaviour with the register reset values
	task automatic test_reset_state();
		send_item(sample(SIDE_IN, SIDE_IN, 20000, 20000));
		send_item(sample(2'd3, SIDE_OUT, -32768, 32767));
		drain();
	endtask

	// walk through every mode but idle and every command branch
	task automatic test_mode_walk();
		in_item_t go;
		set_config(32767, 0, 26, 15000, 26000);
		go = '0;
		go.kind = 1'b1;
		go.left_level = 16'sh8000;
		go.right_level = 16'sh7fff;
		send_item(go);
		send_item(sample(SIDE_IN, SIDE_IN, 20000, 20500));
		send_item(sample(SIDE_IN, SIDE_IN, 30000, 100));
		send_item(sample(SIDE_IN, SIDE_IN, -5, 7));
		send_item(sample(SIDE_IN, SIDE_IN, 400, 400));
		send_item(sample(SIDE_IN, SIDE_OUT, 20000, 20000));
		send_item(sample(SIDE_IN, SIDE_IN, 20000, 20000));
		send_item(sample(SIDE_OUT, SIDE_OUT, 20000, 20000));
		send_item(sample(SIDE_IN, SIDE_OUT, 100, 20000));
		send_item(sample(SIDE_IN, SIDE_OUT, 20000, 100));
		send_item(sample(SIDE_OUT, SIDE_IN, 30000, 27000));
		send_item(sample(SIDE_IN, SIDE_OUT, 20000, 20000));
		send_item(sample(SIDE_MISSING, SIDE_IN, 20000, 20000));
		send_item(sample(SIDE_IN, 2'd3, 20000, 20000));
		send_item(go);
		send_item(sample(SIDE_OUT, SIDE_OUT, 30000, 1000));
		send_item(sample(SIDE_OUT, SIDE_OUT, 30000, 1000));
		send_item(sample(SIDE_OUT, SIDE_OUT, 1000, -30000));
		send_item(sample(SIDE_OUT, SIDE_OUT, 20000, 20000));
		send_item(sample(SIDE_OUT, SIDE_IN, 20000, 20000));
		send_item(sample(SIDE_OUT, SIDE_OUT, 500, 9000));
		send_item(sample(SIDE_IN, SIDE_IN, 500, 9000));
		send_item(sample(SIDE_IN, SIDE_OUT, 500, 9000));
		send_item(go);
		send_item(sample(SIDE_OUT, SIDE_OUT, -32768, 32767));
		drain();
	endtask

	// random traffic under several register settings, extremes included
	task automatic test_config_sweep();
		set_config($urandom_range(0, 32767), 0, 26, 15000, 26000);
		run_random(240);
		drain();
		set_config(32767, 1, 255, 15000, 26000);
		run_random(240);
		drain();
		set_config(0, 0, 0, 0, 32767);
		run_random(200);
		drain();
		set_config(32767, 1, 0, 32767, 0);
		run_random(240);
		drain();
		set_config($urandom_range(0, 32767), $urandom_range(0, 1), $urandom_range(0, 255),
			$urandom_range(0, 32767), $urandom_range(0, 32767));
		run_random(240);
		drain();
	endtask

	// sender holds off mid-stream until the queue has emptied
	task automatic test_drain_pause();
		run_random(100);
		drain();
		run_random(100);
		drain();
	endtask

	// final stretch at full rate on both sides
	task automatic test_steady_tail();
		calm = 1'b1;
		set_config($urandom_range(1, 32767), $urandom_range(0, 1), $urandom_range(0, 255),
			$urandom_range(0, 32767), $urandom_range(0, 32767));
		run_random(300);
		drain();
	endtask

	task automatic report_field(string name, logic signed [31:0] exp_v,
			logic signed [31:0] act_v);
		$display("%0t %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
		errors++;
	endtask

	// receiver with random stall bursts
	always @(posedge clk) begin
		if (cycles % 150 == 0)
			stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 35);
		if (pop_hold > 0) begin
			pop <= 1'b0;
			pop_hold--;
		end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
			pop <= 1'b0;
			pop_hold = $urandom_range(0, 7);
		end else begin
			pop <= 1'b1;
		end
	end

	// check each result beat, then predict for each accepted input beat
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && empty === 1'b0) begin
				if (pending_cmds.size() == 0) begin
					$display("%0t unexpected result beat: expected none, actual %p",
						$time, result);
					errors++;
				end else begin
					want = pending_cmds.pop_front();
					if (result.turn_rate !== want.turn_rate)
						report_field("turn_rate", 32'(want.turn_rate),
							32'(result.turn_rate));
					if (result.forward_speed !== want.forward_speed)
						report_field("forward_speed", 32'(want.forward_speed),
							32'(result.forward_speed));
					if (result.wire_lost !== want.wire_lost)
						report_field("wire_lost", 32'(want.wire_lost),
							32'(result.wire_lost));
					if (result.mode_now !== want.mode_now)
						report_field("mode_now", 32'(want.mode_now),
							32'(result.mode_now));
					cmds_checked++;
					mode_hits[want.mode_now]++;
					if (want.wire_lost)
						lost_seen++;
				end
			end
			if (push && full === 1'b0)
				pending_cmds.push_back(follow_step(item));
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t timeout with %0d commands outstanding", $time, pending_cmds.size());
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		arst_n <= 1'b0;
		push <= 1'b0;
		item <= '0;
		pop <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_TARGET_SPEED;
		cfg_data <= '0;
		tgt_speed = 0;
		follow_rev = 1'b0;
		margin = 26;
		near_lvl = 15000;
		far_lvl = 26000;
		nav_mode = MODE_IDLE;
		entry_sd = 2'd0;
		errors = 0;
		items_sent = 0;
		cmds_checked = 0;
		lost_seen = 0;
		cycles = 0;
		gap_pct = 0;
		stall_pct = 0;
		pop_hold = 0;
		calm = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_mode_walk();
		test_config_sweep();
		test_drain_pause();
		test_steady_tail();

		$display("run: %0d samples and starts sent, %0d commands checked, %0d lost-wire",
			items_sent, cmds_checked, lost_seen);
		$display("run: per mode idle %0d start %0d finddir %0d gotoline %0d align %0d trace %0d",
			mode_hits[MODE_IDLE], mode_hits[MODE_START], mode_hits[MODE_FINDDIR],
			mode_hits[MODE_GOTO], mode_hits[MODE_ALIGN], mode_hits[MODE_TRACE]);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
